### rtl/oaht_pkg.sv
// ----------------------------------------------------------------------------
// oaht_pkg
// Shared types and constants for the open-addressing hash table.
// ----------------------------------------------------------------------------
package oaht_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int SIZE_W       = 5;
  localparam int KEY_W        = 31;
  localparam int VAL_W        = 32;
  localparam int STS_W        = 2;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 5;
  localparam int MOD_STEPS    = 16;   // two key bits per step over a 32-bit word
  localparam int MOD_CNT_W    = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_PROBE_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = 1'd1;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;
  localparam logic [SIZE_W-1:0] SIZE_MIN   = 5'd2;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_SEARCH = 1'b1
  } action_t;

  typedef enum logic [STS_W-1:0] {
    STS_INSERTED = 2'd0,
    STS_FAILED   = 2'd1,
    STS_FOUND    = 2'd2,
    STS_MISSING  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_START,
    ST_PROBE,
    ST_CMP,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic                    action;
    logic [KEY_W-1:0]        key;
    logic signed [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [STS_W-1:0]        status;
    logic signed [VAL_W-1:0] read_value;
  } out_item_t;

  typedef struct packed {
    logic             load;
    logic             mod_step;
    logic             probe_init;
    logic             advance;
    logic             write;
    logic             set_res;
    logic [STS_W-1:0] res_status;
    logic             res_take_rd;
    logic             out_load;
  } cmd_t;

  typedef struct packed {
    logic is_search;
    logic mod_last;
    logic full;
    logic used;
    logic match;
    logic last_probe;
  } sts_t;

endpackage

### rtl/open_addressing_hash_table.sv
// ----------------------------------------------------------------------------
// open_addressing_hash_table
// Open-addressing key/value table, linear probing or double hashing.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid/in_ready    oaht_pkg::in_item_t
//   out_     output     out_valid/out_ready  oaht_pkg::out_item_t
//   cfg_     input      cfg_we               cfg_index, cfg_wdata
//
// Accept to out_valid: a serial key modulo (MOD), then up to S probes; an
// insert into a table that is already full skips the probes. An insert probe
// checks occupancy only; a search probe also reads the registered slot RAM
// and compares the key in CMP, except when it stops at a free slot. The
// controller passes through IDLE before the next transaction is taken.
// Reset clears occupancy, entry count and config; no clearing pass.
// A new transaction is taken while the previous result waits on out_ready.
// ----------------------------------------------------------------------------
module open_addressing_hash_table #(
  parameter int CAPACITY = oaht_pkg::CAPACITY_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  oaht_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output oaht_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [oaht_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [oaht_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  oaht_pkg::cmd_t cmd;
  oaht_pkg::sts_t sts;

  oaht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  oaht_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

  // one transaction at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while busy");

  // a slot is written only when free
  a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write |-> !sts.used)
    else $error("write to occupied slot");

  // never write into a full table
  a_write_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write |-> !sts.full)
    else $error("write with table full");

endmodule

### rtl/oaht_ram.sv
// ----------------------------------------------------------------------------
// oaht_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module oaht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/oaht_ctrl.sv
// ----------------------------------------------------------------------------
// oaht_ctrl
// Sequencer: key hashing, probe walk, result hand-off.
// ----------------------------------------------------------------------------
module oaht_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  oaht_pkg::sts_t       sts,
  output oaht_pkg::cmd_t       cmd
);

  oaht_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= oaht_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      oaht_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = oaht_pkg::ST_MOD;
      end
      oaht_pkg::ST_MOD: begin
        if (sts.mod_last) state_nxt = oaht_pkg::ST_START;
      end
      oaht_pkg::ST_START: begin
        if (!sts.is_search && sts.full) state_nxt = oaht_pkg::ST_RESP;
        else                            state_nxt = oaht_pkg::ST_PROBE;
      end
      oaht_pkg::ST_PROBE: begin
        if (!sts.used) state_nxt = oaht_pkg::ST_RESP;
        else if (sts.is_search) state_nxt = oaht_pkg::ST_CMP;
        else if (sts.last_probe) state_nxt = oaht_pkg::ST_RESP;
      end
      oaht_pkg::ST_CMP: begin
        if (sts.match || sts.last_probe) state_nxt = oaht_pkg::ST_RESP;
        else                             state_nxt = oaht_pkg::ST_PROBE;
      end
      oaht_pkg::ST_RESP: begin
        if (out_free) state_nxt = oaht_pkg::ST_IDLE;
      end
      default: state_nxt = oaht_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      oaht_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      oaht_pkg::ST_MOD: begin
        cmd.mod_step = 1'b1;
      end
      oaht_pkg::ST_START: begin
        cmd.probe_init = 1'b1;
        if (!sts.is_search && sts.full) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = oaht_pkg::STS_FAILED;
        end
      end
      oaht_pkg::ST_PROBE: begin
        if (!sts.used) begin
          cmd.set_res = 1'b1;
          if (sts.is_search) begin
            cmd.res_status = oaht_pkg::STS_MISSING;
          end else begin
            cmd.write      = 1'b1;
            cmd.res_status = oaht_pkg::STS_INSERTED;
          end
        end else if (sts.is_search) begin
          // slot read in flight, key compared next cycle
        end else if (sts.last_probe) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = oaht_pkg::STS_FAILED;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      oaht_pkg::ST_CMP: begin
        if (sts.match) begin
          cmd.set_res     = 1'b1;
          cmd.res_status  = oaht_pkg::STS_FOUND;
          cmd.res_take_rd = 1'b1;
        end else if (sts.last_probe) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = oaht_pkg::STS_MISSING;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      oaht_pkg::ST_RESP: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

### rtl/oaht_dp.sv
// ----------------------------------------------------------------------------
// oaht_dp
// Datapath: config registers, serial key modulo, probe arithmetic,
// occupancy bits, slot RAM and result registers.
// ----------------------------------------------------------------------------
module oaht_dp #(
  parameter int CAPACITY = oaht_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [oaht_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [oaht_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  oaht_pkg::in_item_t                in_data,
  output oaht_pkg::out_item_t               out_data,
  input  oaht_pkg::cmd_t                    cmd,
  output oaht_pkg::sts_t                    sts
);

  localparam int SW = oaht_pkg::SIZE_W;
  // slots at or above the largest reachable size are never touched
  localparam int MAX_S = (1 << SW) - 1;
  localparam int UD = (CAPACITY < MAX_S) ? CAPACITY : MAX_S;
  localparam int UW = (UD > 1) ? $clog2(UD) : 1;
  localparam int CW = $clog2(UD + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int KW = oaht_pkg::KEY_W;
  localparam int VW = oaht_pkg::VAL_W;
  localparam int RW = KW + VW;

  logic          probe_mode_r;
  logic [SW-1:0] table_size_r;

  logic          action_r;
  logic [KW-1:0] key_r;
  logic [VW-1:0] value_r;
  logic [KW:0]   key_sh_r;
  logic [oaht_pkg::MOD_CNT_W-1:0] mod_cnt_r;
  logic [SW-1:0] s_r, s_nxt;
  logic [SW-1:0] rem_h_r, rem_s_r;
  logic [SW-1:0] cur_r, stride_r, pcnt_r;
  logic [SW:0]   sum;
  logic [UD-1:0] used_r;
  logic [CW-1:0] count_r;
  logic [oaht_pkg::STS_W-1:0] res_status_r;
  logic [VW-1:0] res_value_r;
  oaht_pkg::out_item_t out_r;
  logic [RW-1:0] rdata;
  logic [AW-1:0] addr;

  function automatic logic [SW-1:0] mod_step2(input logic [SW-1:0] r,
                                              input logic [1:0] b,
                                              input logic [SW-1:0] d);
    logic [SW:0] t;
    t = {r, b[1]};
    if (t >= {1'b0, d}) t = t - {1'b0, d};
    t = {t[SW-1:0], b[0]};
    if (t >= {1'b0, d}) t = t - {1'b0, d};
    return t[SW-1:0];
  endfunction

  // saturate configured size to 2..min(capacity, 31)
  always_comb begin
    s_nxt = table_size_r;
    if (table_size_r < oaht_pkg::SIZE_MIN) s_nxt = oaht_pkg::SIZE_MIN;
    else if (32'(table_size_r) > UD)       s_nxt = SW'(UD);
  end

  assign sum  = {1'b0, cur_r} + {1'b0, stride_r};
  assign addr = AW'(cur_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_mode_r <= 1'b0;
      table_size_r <= oaht_pkg::SIZE_RESET;
      used_r       <= '0;
      count_r      <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          oaht_pkg::CFG_PROBE_MODE: probe_mode_r <= cfg_wdata[0];
          oaht_pkg::CFG_TABLE_SIZE: table_size_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.write) begin
        used_r[cur_r[UW-1:0]] <= 1'b1;
        count_r               <= count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r  <= in_data.action;
      key_r     <= in_data.key;
      value_r   <= in_data.value;
      key_sh_r  <= {1'b0, in_data.key};
      mod_cnt_r <= '0;
      s_r       <= s_nxt;
      rem_h_r   <= '0;
      rem_s_r   <= '0;
    end
    if (cmd.mod_step) begin
      rem_h_r   <= mod_step2(rem_h_r, key_sh_r[KW:KW-1], s_r);
      rem_s_r   <= mod_step2(rem_s_r, key_sh_r[KW:KW-1], s_r - 1'b1);
      key_sh_r  <= {key_sh_r[KW-2:0], 2'b00};
      mod_cnt_r <= mod_cnt_r + 1'b1;
    end
    if (cmd.probe_init) begin
      cur_r    <= rem_h_r;
      stride_r <= probe_mode_r ? rem_s_r + 1'b1 : SW'(1);
      pcnt_r   <= '0;
    end
    if (cmd.advance) begin
      cur_r  <= (sum >= {1'b0, s_r}) ? SW'(sum - {1'b0, s_r}) : sum[SW-1:0];
      pcnt_r <= pcnt_r + 1'b1;
    end
    if (cmd.set_res) begin
      res_status_r <= cmd.res_status;
      res_value_r  <= cmd.res_take_rd ? rdata[VW-1:0] : '0;
    end
    if (cmd.out_load) begin
      out_r.status     <= res_status_r;
      out_r.read_value <= res_value_r;
    end
  end

  oaht_ram #(
    .WIDTH (RW),
    .DEPTH (CAPACITY)
  ) u_slot_ram (
    .clk   (clk),
    .we    (cmd.write),
    .waddr (addr),
    .wdata ({key_r, value_r}),
    .raddr (addr),
    .rdata (rdata)
  );

  assign sts.is_search  = (action_r == oaht_pkg::ACT_SEARCH);
  assign sts.mod_last   = (mod_cnt_r == oaht_pkg::MOD_CNT_W'(oaht_pkg::MOD_STEPS - 1));
  assign sts.full       = (SW'(count_r) >= s_r);
  assign sts.used       = used_r[cur_r[UW-1:0]];
  assign sts.match      = (rdata[RW-1:VW] == key_r);
  assign sts.last_probe = (pcnt_r == s_r - 1'b1);

  assign out_data = out_r;

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the open-addressing hash table.
// An in-bench scoreboard model tracks occupancy, keys and values for both
// probe modes and every table size. Each result is compared in order. Both
// handshakes get random stalls, including one long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

  localparam int SLOTS      = oaht_pkg::CAPACITY_DEF;
  localparam int DRAIN_CYC  = 80;
  localparam int CYCLE_LIMIT = 2_000_000;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  oaht_pkg::in_item_t            in_data = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  oaht_pkg::out_item_t           out_data;
  logic                          cfg_we = 1'b0;
  logic [oaht_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [oaht_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  open_addressing_hash_table uut (.*);

  always #5 clk = ~clk;

  // scoreboard model of the table
  logic                       mdl_double;
  logic [oaht_pkg::SIZE_W-1:0] mdl_size;
  logic                       mdl_used [SLOTS];
  logic [oaht_pkg::KEY_W-1:0] mdl_key  [SLOTS];
  logic [oaht_pkg::VAL_W-1:0] mdl_val  [SLOTS];
  int                         mdl_count;

  oaht_pkg::out_item_t        pending_q[$];
  logic [oaht_pkg::KEY_W-1:0] stored_keys[$];
  int               err_cnt = 0;
  int               sent_cnt = 0;
  int               rcvd_cnt = 0;
  int               found_cnt = 0;
  int               fail_cnt = 0;
  int               cycles = 0;
  bit               quiet = 1'b0;
  bit               hold_req = 1'b0;

  function automatic oaht_pkg::out_item_t lookup_result(oaht_pkg::in_item_t it);
    oaht_pkg::out_item_t r;
    int s, home, stride, at;
    r = '{status: (it.action == oaht_pkg::ACT_INSERT) ? oaht_pkg::STS_FAILED
                                                       : oaht_pkg::STS_MISSING,
          read_value: '0};
    s = int'(mdl_size);
    if (s < 2) s = 2;
    if (s > SLOTS) s = SLOTS;
    home = it.key % s;
    stride = mdl_double ? 1 + it.key % (s - 1) : 1;
    if (it.action == oaht_pkg::ACT_INSERT) begin
      if (mdl_count < s) begin
        for (int i = 0; i < s; i++) begin
          at = (home + i * stride) % s;
          if (!mdl_used[at]) begin
            mdl_used[at] = 1'b1;
            mdl_key[at] = it.key;
            mdl_val[at] = it.value;
            mdl_count++;
            stored_keys.push_back(it.key);
            r.status = oaht_pkg::STS_INSERTED;
            break;
          end
        end
      end
    end else begin
      for (int i = 0; i < s; i++) begin
        at = (home + i * stride) % s;
        if (!mdl_used[at]) break;
        if (mdl_key[at] == it.key) begin
          r.status = oaht_pkg::STS_FOUND;
          r.read_value = mdl_val[at];
          break;
        end
      end
    end
    return r;
  endfunction

  // output ready: random stalls, one long hold-off on request
  int stall_left = 0;
  always @(negedge clk) begin
    if (hold_req) begin
      stall_left = 300;
      hold_req = 1'b0;
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if (!quiet) begin
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) stall_left = $urandom_range(1, 3);
        else if (r < 22) stall_left = $urandom_range(10, 40);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      rcvd_cnt++;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected transaction status=%0d value=%0d", $time,
                 out_data.status, out_data.read_value);
        err_cnt++;
      end else begin
        oaht_pkg::out_item_t e;
        e = pending_q.pop_front();
        if (out_data.status !== e.status) begin
          $display("%0t: status mismatch exp=%0d act=%0d", $time, e.status,
                   out_data.status);
          err_cnt++;
        end
        if (out_data.read_value !== e.read_value) begin
          $display("%0t: read_value mismatch exp=%0d act=%0d", $time,
                   e.read_value, out_data.read_value);
          err_cnt++;
        end
        if (e.status == oaht_pkg::STS_FOUND) found_cnt++;
        if (e.status == oaht_pkg::STS_FAILED) fail_cnt++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("open_addressing_hash_table test failed");
      $finish;
    end
  end

  task automatic send_item(oaht_pkg::action_t act, logic [oaht_pkg::KEY_W-1:0] key,
                           logic [oaht_pkg::VAL_W-1:0] val);
    oaht_pkg::in_item_t it;
    int gap;
    it = '{action: act, key: key, value: val};
    gap = 0;
    if (!quiet) begin
      int r;
      r = $urandom_range(0, 99);
      if (r < 30) gap = $urandom_range(1, 3);
      else if (r < 33) gap = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    pending_q.push_back(lookup_result(it));
    sent_cnt++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_cfg(logic [oaht_pkg::CFG_IDX_W-1:0] idx,
                           logic [oaht_pkg::CFG_DATA_W-1:0] val);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == oaht_pkg::CFG_PROBE_MODE) mdl_double = val[0];
    else mdl_size = val;
  endtask

  task automatic set_mode(logic dbl, logic [oaht_pkg::CFG_DATA_W-1:0] sz);
    write_cfg(oaht_pkg::CFG_PROBE_MODE, {4'd0, dbl});
    write_cfg(oaht_pkg::CFG_TABLE_SIZE, sz);
  endtask

  task automatic test_directed();
    set_mode(1'b0, 5'd2);
    send_item(oaht_pkg::ACT_SEARCH, 31'd0, 32'd5);           // empty table
    send_item(oaht_pkg::ACT_INSERT, 31'd0, 32'h7FFFFFFF);
    send_item(oaht_pkg::ACT_INSERT, 31'd2, 32'h1);           // collides, next slot
    send_item(oaht_pkg::ACT_INSERT, 31'd4, 32'h2);           // table full
    send_item(oaht_pkg::ACT_SEARCH, 31'd2, 32'hFFFFFFFF);
    send_item(oaht_pkg::ACT_SEARCH, 31'd4, 32'h0);           // misses after S probes
    send_item(oaht_pkg::ACT_SEARCH, 31'h7FFFFFFF, 32'h0);
    set_mode(1'b1, 5'd5);
    send_item(oaht_pkg::ACT_INSERT, 31'd7, 32'h80000000);
    send_item(oaht_pkg::ACT_INSERT, 31'd12, 32'h12345678);
    send_item(oaht_pkg::ACT_INSERT, 31'd7, 32'hDEADBEEF);    // duplicate key
    send_item(oaht_pkg::ACT_SEARCH, 31'd7, 32'h0);
    send_item(oaht_pkg::ACT_INSERT, 31'h7FFFFFFF, 32'h55AA55AA);
    send_item(oaht_pkg::ACT_SEARCH, 31'h7FFFFFFF, 32'h0);
    set_mode(1'b0, 5'd0);                                    // saturates to two slots
    send_item(oaht_pkg::ACT_INSERT, 31'd9, 32'h3);
    send_item(oaht_pkg::ACT_SEARCH, 31'd0, 32'h0);
    set_mode(1'b1, 5'd31);                                   // saturates to sixteen
    send_item(oaht_pkg::ACT_INSERT, 31'd17, 32'h4);
    send_item(oaht_pkg::ACT_SEARCH, 31'd12, 32'h0);
    set_mode(1'b0, 5'd1);
    send_item(oaht_pkg::ACT_SEARCH, 31'd2, 32'h0);
    set_mode(1'b1, 5'd16);
    send_item(oaht_pkg::ACT_SEARCH, 31'd7, 32'h0);
    send_item(oaht_pkg::ACT_SEARCH, 31'd4, 32'h0);
  endtask

  task automatic send_random(int n);
    for (int i = 0; i < n; i++) begin
      logic [oaht_pkg::KEY_W-1:0] k;
      int r;
      r = $urandom_range(0, 99);
      if (r < 50 && stored_keys.size() != 0)
        k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
      else if (r < 80) k = oaht_pkg::KEY_W'($urandom_range(0, 40));
      else k = oaht_pkg::KEY_W'($urandom);
      send_item(($urandom_range(0, 99) < 60) ? oaht_pkg::ACT_SEARCH : oaht_pkg::ACT_INSERT,
                k, $urandom);
    end
  endtask

  task automatic test_random();
    logic [oaht_pkg::CFG_DATA_W-1:0] sizes[14] = '{5'd3, 5'd16, 5'd8, 5'd0, 5'd31, 5'd2,
                                                   5'd12, 5'd17, 5'd1, 5'd16, 5'd6,
                                                   5'd15, 5'd9, 5'd16};
    for (int p = 0; p < 14; p++) begin
      set_mode(p[0], sizes[p]);
      quiet = (p % 5 == 4);
      send_random(95);
    end
    quiet = 1'b0;
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    send_random(20);
  endtask

  task automatic test_pause();
    wait_idle();
    send_random(20);
  endtask

  initial begin
    mdl_double = 1'b0;
    mdl_size = oaht_pkg::SIZE_RESET;
    mdl_count = 0;
    foreach (mdl_used[i]) mdl_used[i] = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_backpressure();
    test_pause();
    test_random();
    wait_idle();
    $display("sent %0d transactions, checked %0d (%0d found, %0d failed inserts)",
             sent_cnt, rcvd_cnt, found_cnt, fail_cnt);
    $display("covered both probe modes, saturated sizes, full table and stalls");
    if (err_cnt == 0 && pending_q.size() == 0) begin
      $display("open_addressing_hash_table test passed");
    end else begin
      $display("open_addressing_hash_table test failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/oaht_pkg.sv
rtl/oaht_ram.sv
rtl/oaht_ctrl.sv
rtl/oaht_dp.sv
rtl/open_addressing_hash_table.sv
verif/tb_top.sv
